@@ rtl/ffa_pkg.sv @@
package ffa_pkg;
	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_BLOCKS   = 256;
	localparam int RESULT_SPAN  = 4096;
	localparam int SW = $clog2(MAX_BLOCKS);
	localparam int AW = $clog2(ARENA_BYTES) + 1;
	localparam int PW = SW + 1;
	localparam logic [PW-1:0] NONE = PW'(MAX_BLOCKS);
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;
	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
		logic [PW-1:0] next;
		logic [PW-1:0] prev;
	} entry_t;
endpackage

@@ rtl/ffa_table.sv @@
module ffa_table (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ffa_pkg::SW-1:0] waddr,
	input  ffa_pkg::entry_t      wdata,
	input  logic [ffa_pkg::SW-1:0] raddr,
	output ffa_pkg::entry_t      rdata
);
	import ffa_pkg::*;
	entry_t mem [MAX_BLOCKS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/first_fit_arena_allocator_top.sv @@
// First-fit arena allocator: block list lives in a one-read, one-write table RAM.
// Steps: free/resize scan the slots for the block at data_offset; a resize stays put
// if the following gap allows, else it allocates anew. Allocate walks the list first
// fit, then links the new block; free and a moving resize unlink the old block.
// One item at a time: busy stays high through done. The unused action does nothing.
// Reset: valid map cleared, list empty, at once; no clearing pass. No receiver stall.
module first_fit_arena_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [11:0] data_offset,
	input  logic [11:0] request_bytes,
	output logic        done,
	output logic [11:0] result_offset,
	output logic [1:0]  status,
	output logic        moved
);
	import ffa_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0, S_LOOK = 5'd1, S_LOOKW = 5'd2,
		S_RSZ = 5'd3, S_RSZW = 5'd4, S_AFREE = 5'd5, S_AHEAD = 5'd6,
		S_AHW = 5'd7, S_WALK = 5'd8, S_WALKW = 5'd9, S_LINK = 5'd10,
		S_LPREV = 5'd11, S_LPW = 5'd12, S_LNEXT = 5'd13, S_LNW = 5'd14,
		S_REL = 5'd15, S_RELW = 5'd16, S_RELP = 5'd17, S_RELPW = 5'd18,
		S_RELN = 5'd19, S_RELNW = 5'd20, S_DONE = 5'd21;

	logic [4:0] st_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [PW-1:0] head_q;
	logic [1:0]  act_q;
	logic [11:0] doff_q;
	logic [AW-1:0] need_q;
	logic [SW:0] idx_q;
	logic [PW-1:0] slot_q, nslot_q, cur_q, p_q, n_q;
	entry_t cur_e_q;
	logic [AW-1:0] nstart_q;
	logic [11:0] res_q;
	logic [1:0] stat_q;
	logic mv_q;

	logic we; logic [SW-1:0] waddr, raddr; entry_t wdata, rdata;
	ffa_table u_tab (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	// first free slot, priority encode over valid bits
	logic [PW-1:0] free_slot;
	always_comb begin
		free_slot = NONE;
		for (int i = MAX_BLOCKS-1; i >= 0; i--)
			if (!valid_q[i]) free_slot = PW'(i);
	end

	// cur_e_q is the block under test; rdata holds its successor's entry
	logic [AW-1:0] endv, gap_lim;
	logic fit_grow, fit_walk;
	assign endv = cur_e_q.start + cur_e_q.size;
	assign gap_lim = (cur_e_q.next == NONE) ? AW'(ARENA_BYTES) : rdata.start;
	// shrink always fits; grow needs the following gap
	assign fit_grow = (need_q <= cur_e_q.size) ||
		(gap_lim >= endv && gap_lim - endv >= need_q - cur_e_q.size);
	// a gap whose data offset would not fit in 12 bits is passed over
	assign fit_walk = gap_lim >= endv && gap_lim - endv >= need_q &&
		endv + AW'(HEADER_BYTES) < AW'(RESULT_SPAN);

	// table port: reads issued one state ahead; link writes a fresh entry, others patch read data
	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		unique case (st_q)
			S_LOOK: raddr = idx_q[SW-1:0];
			S_RSZ, S_AHEAD, S_WALK: raddr = cur_q[SW-1:0];
			S_LPREV, S_RELP: raddr = p_q[SW-1:0];
			S_LNEXT, S_RELN: raddr = n_q[SW-1:0];
			S_REL: raddr = slot_q[SW-1:0];
			S_RSZW: if (fit_grow) begin
				we = 1'b1; waddr = slot_q[SW-1:0];
				wdata = cur_e_q; wdata.size = need_q;
			end
			S_LINK: begin
				we = 1'b1; waddr = nslot_q[SW-1:0];
				wdata = '{start: nstart_q, size: need_q, next: n_q, prev: p_q};
			end
			S_LPW: if (p_q != NONE) begin
				we = 1'b1; waddr = p_q[SW-1:0]; wdata.next = nslot_q;
			end
			S_LNW: if (n_q != NONE) begin
				we = 1'b1; waddr = n_q[SW-1:0]; wdata.prev = nslot_q;
			end
			S_RELPW: if (p_q != NONE) begin
				we = 1'b1; waddr = p_q[SW-1:0]; wdata.next = n_q;
			end
			S_RELNW: if (n_q != NONE) begin
				we = 1'b1; waddr = n_q[SW-1:0]; wdata.prev = p_q;
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_DONE);
	assign result_offset = res_q;
	assign status = stat_q;
	assign moved = mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; valid_q <= '0; head_q <= NONE;
			act_q <= ACT_ALLOC; doff_q <= '0; need_q <= '0; idx_q <= '0;
			slot_q <= '0; nslot_q <= '0; cur_q <= '0; p_q <= NONE; n_q <= NONE;
			cur_e_q <= '0; nstart_q <= '0;
			res_q <= '0; stat_q <= ST_OK; mv_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) begin
					act_q <= action; doff_q <= data_offset;
					need_q <= AW'(request_bytes) + AW'(HEADER_BYTES);
					res_q <= '0; stat_q <= ST_OK; mv_q <= 1'b0; idx_q <= '0;
					if (action == ACT_ALLOC) st_q <= S_AFREE;
					else if (action == ACT_NONE) st_q <= S_DONE;
					else st_q <= S_LOOK;
				end
				S_LOOK: begin
					if (idx_q == (SW+1)'(MAX_BLOCKS)) begin
						stat_q <= ST_BADADDR; st_q <= S_DONE;
					end else st_q <= S_LOOKW;
				end
				S_LOOKW: begin
					if (valid_q[idx_q[SW-1:0]] &&
					    rdata.start + AW'(HEADER_BYTES) == {1'b0, doff_q}) begin
						slot_q <= idx_q; cur_e_q <= rdata; cur_q <= rdata.next;
						st_q <= (act_q == ACT_FREE) ? S_REL : S_RSZ;
					end else begin
						idx_q <= idx_q + 1'b1; st_q <= S_LOOK;
					end
				end
				S_RSZ: st_q <= S_RSZW;
				S_RSZW: begin
					if (fit_grow) begin
						res_q <= doff_q; st_q <= S_DONE;
					end else st_q <= S_AFREE;
				end
				S_AFREE: begin
					if (need_q > AW'(ARENA_BYTES) || free_slot == NONE) begin
						stat_q <= ST_NOSPACE; st_q <= S_DONE;
					end else begin
						nslot_q <= free_slot;
						if (head_q == NONE) begin
							nstart_q <= '0; p_q <= NONE; n_q <= NONE; st_q <= S_LINK;
						end else begin
							cur_q <= head_q; st_q <= S_AHEAD;
						end
					end
				end
				S_AHEAD: st_q <= S_AHW;
				S_AHW: begin
					if (rdata.start >= need_q) begin
						nstart_q <= '0; p_q <= NONE; n_q <= head_q; st_q <= S_LINK;
					end else begin
						cur_e_q <= rdata; p_q <= cur_q; cur_q <= rdata.next;
						st_q <= S_WALK;
					end
				end
				S_WALK: st_q <= S_WALKW;
				S_WALKW: begin
					if (fit_walk) begin
						nstart_q <= endv; n_q <= cur_e_q.next; st_q <= S_LINK;
					end else if (cur_e_q.next == NONE) begin
						stat_q <= ST_NOSPACE; st_q <= S_DONE;
					end else begin
						cur_e_q <= rdata; p_q <= cur_q; cur_q <= rdata.next;
						st_q <= S_WALK;
					end
				end
				S_LINK: begin
					valid_q[nslot_q[SW-1:0]] <= 1'b1;
					if (p_q == NONE) head_q <= nslot_q;
					res_q <= 12'(nstart_q + AW'(HEADER_BYTES));
					if (act_q == ACT_RESIZE) mv_q <= 1'b1;
					st_q <= S_LPREV;
				end
				S_LPREV: st_q <= S_LPW;
				S_LPW: st_q <= S_LNEXT;
				S_LNEXT: st_q <= S_LNW;
				// old block is reread on a move; its links may have changed
				S_LNW: st_q <= (act_q == ACT_RESIZE) ? S_REL : S_DONE;
				S_REL: st_q <= S_RELW;
				S_RELW: begin
					p_q <= rdata.prev; n_q <= rdata.next;
					if (rdata.prev == NONE) head_q <= rdata.next;
					valid_q[slot_q[SW-1:0]] <= 1'b0;
					st_q <= S_RELP;
				end
				S_RELP: st_q <= S_RELPW;
				S_RELPW: st_q <= S_RELN;
				S_RELN: st_q <= S_RELNW;
				S_RELNW: st_q <= S_DONE;
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/first_fit_arena_allocator_top_tb.sv @@
`timescale 1ns / 1ps

module first_fit_arena_allocator_top_tb;
	import ffa_pkg::*;

	localparam int RANDOM_ITEMS = 1630;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 40;

	typedef struct {
		logic [11:0] offset;
		logic [1:0]  st;
		logic        mv;
	} grant_t;

	typedef struct {
		logic [1:0]  act;
		logic [11:0] off;
		logic [11:0] req;
		bit          typed;
		grant_t      want;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = ACT_ALLOC;
	logic [11:0] data_offset = 12'd0;
	logic [11:0] request_bytes = 12'd0;
	logic        busy;
	logic        done;
	logic [11:0] result_offset;
	logic [1:0]  status;
	logic        moved;

	first_fit_arena_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.data_offset(data_offset),
		.request_bytes(request_bytes),
		.done(done),
		.result_offset(result_offset),
		.status(status),
		.moved(moved)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the block list: address-ordered, doubly linked over slots.
	// MAX_BLOCKS stands for "no slot".
	// ---------------------------------------------------------------
	int blk_start [MAX_BLOCKS];
	int blk_size  [MAX_BLOCKS];
	int blk_next  [MAX_BLOCKS];
	int blk_prev  [MAX_BLOCKS];
	bit blk_live  [MAX_BLOCKS];
	int list_head = MAX_BLOCKS;

	grant_t pending_grants[$];
	int     live_offs[$];
	int     errors = 0;
	int     cycles = 0;
	int     gap_pct = 0;

	// slot whose user data sits at offset d, or MAX_BLOCKS
	function automatic int find_block(int d);
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (blk_live[i] && blk_start[i] + HEADER_BYTES == d)
				return i;
		return MAX_BLOCKS;
	endfunction

	// where the gap after slot s ends
	function automatic int gap_end(int s);
		return (blk_next[s] < MAX_BLOCKS) ? blk_start[blk_next[s]] : ARENA_BYTES;
	endfunction

	function automatic bit place_block(int need, output int d);
		int slot, base, p, n, cur, e, lim;
		bit found;
		slot = MAX_BLOCKS;
		base = 0;
		p = MAX_BLOCKS;
		n = MAX_BLOCKS;
		found = 1'b0;
		d = 0;
		if (need > ARENA_BYTES)
			return 1'b0;
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (!blk_live[i]) begin
				slot = i;
				break;
			end
		if (slot == MAX_BLOCKS)
			return 1'b0;
		if (list_head >= MAX_BLOCKS) begin
			found = 1'b1;
		end else if (blk_start[list_head] >= need) begin
			n = list_head;
			found = 1'b1;
		end else begin
			cur = list_head;
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				e = blk_start[cur] + blk_size[cur];
				lim = gap_end(cur);
				// a gap whose data offset won't fit in 12 bits is passed over
				if (lim >= e && lim - e >= need && e + HEADER_BYTES < RESULT_SPAN) begin
					base = e;
					p = cur;
					n = blk_next[cur];
					found = 1'b1;
					break;
				end
				if (blk_next[cur] >= MAX_BLOCKS)
					break;
				cur = blk_next[cur];
			end
		end
		if (!found)
			return 1'b0;
		blk_start[slot] = base;
		blk_size[slot] = need;
		blk_next[slot] = n;
		blk_prev[slot] = p;
		blk_live[slot] = 1'b1;
		if (p < MAX_BLOCKS)
			blk_next[p] = slot;
		else
			list_head = slot;
		if (n < MAX_BLOCKS)
			blk_prev[n] = slot;
		d = base + HEADER_BYTES;
		return 1'b1;
	endfunction

	function automatic void unlink_block(int s);
		if (blk_prev[s] < MAX_BLOCKS)
			blk_next[blk_prev[s]] = blk_next[s];
		else
			list_head = blk_next[s];
		if (blk_next[s] < MAX_BLOCKS)
			blk_prev[blk_next[s]] = blk_prev[s];
		blk_live[s] = 1'b0;
		blk_start[s] = 0;
		blk_size[s] = 0;
		blk_next[s] = 0;
		blk_prev[s] = 0;
	endfunction

	// expected answer to one item, updating the shadow list
	function automatic grant_t model_item(logic [1:0] a, int d, int req);
		grant_t g;
		int s, need, e, lim, nd;
		g = '{12'd0, ST_OK, 1'b0};
		need = req + HEADER_BYTES;
		case (a)
			ACT_ALLOC: begin
				if (place_block(need, nd))
					g.offset = 12'(nd);
				else
					g.st = ST_NOSPACE;
			end
			ACT_FREE: begin
				s = find_block(d);
				if (s < MAX_BLOCKS)
					unlink_block(s);
				else
					g.st = ST_BADADDR;
			end
			ACT_RESIZE: begin
				s = find_block(d);
				if (s >= MAX_BLOCKS) begin
					g.st = ST_BADADDR;
				end else begin
					e = blk_start[s] + blk_size[s];
					lim = gap_end(s);
					// shrink always stays; grow stays when the next gap is wide enough
					if (need <= blk_size[s] || (lim >= e && lim - e >= need - blk_size[s])) begin
						blk_size[s] = need;
						g.offset = 12'(d);
					end else if (place_block(need, nd)) begin
						// new block is placed while the old one is still live
						unlink_block(s);
						g.offset = 12'(nd);
						g.mv = 1'b1;
					end else begin
						g.st = ST_NOSPACE;
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	// One item through the start/busy handshake. The expectation is queued at
	// the accepting edge; a typed row queues its typed answer instead.
	task automatic issue(input logic [1:0] a, input int d, input int req,
			input bit typed, input grant_t want, output grant_t got);
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= a;
		data_offset <= d[11:0];
		request_bytes <= req[11:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		got = model_item(a, d, req);
		pending_grants.push_back(typed ? want : got);
	endtask

	// Result checker: done marks a one-cycle result that cannot be held off.
	always @(posedge clk) begin
		grant_t w;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: result with nothing expected: offset %0d status %0d moved %0d",
					$time, result_offset, status, moved);
				errors++;
			end else begin
				w = pending_grants.pop_front();
				if (result_offset !== w.offset) begin
					$display("%0t: result_offset expected %0d actual %0d",
						$time, w.offset, result_offset);
					errors++;
				end
				if (status !== w.st) begin
					$display("%0t: status expected %0d actual %0d", $time, w.st, status);
					errors++;
				end
				if (moved !== w.mv) begin
					$display("%0t: moved expected %0d actual %0d", $time, w.mv, moved);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cmd_t   plan[$];
		grant_t got, none;
		int     idx, pick, req, d, fill;

		none = '{12'd0, ST_OK, 1'b0};
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			blk_start[i] = 0;
			blk_size[i] = 0;
			blk_next[i] = 0;
			blk_prev[i] = 0;
			blk_live[i] = 1'b0;
		end

		// Directed rows. Answers are typed where obvious; the rest go to the predictor.
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd0,    1'b1, '{12'd16, ST_OK, 1'b0}});
		plan.push_back('{ACT_FREE,   12'd16,   12'd0,    1'b1, '{12'd0, ST_OK, 1'b0}});
		// free of a block already gone, resize of an unknown offset
		plan.push_back('{ACT_FREE,   12'd16,   12'd0,    1'b1, '{12'd0, ST_BADADDR, 1'b0}});
		plan.push_back('{ACT_RESIZE, 12'd16,   12'd5,    1'b1, '{12'd0, ST_BADADDR, 1'b0}});
		// unused action does nothing
		plan.push_back('{ACT_NONE,   12'd4095, 12'd4095, 1'b1, '{12'd0, ST_OK, 1'b0}});
		// header pushes this past the arena
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd4095, 1'b1, '{12'd0, ST_NOSPACE, 1'b0}});
		// exactly the whole arena, then nothing left
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd4080, 1'b1, '{12'd16, ST_OK, 1'b0}});
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd0,    1'b1, '{12'd0, ST_NOSPACE, 1'b0}});
		// shrink to header only, then grow in place up to 16 bytes short of the end
		plan.push_back('{ACT_RESIZE, 12'd16,   12'd0,    1'b1, '{12'd16, ST_OK, 1'b0}});
		plan.push_back('{ACT_RESIZE, 12'd16,   12'd4064, 1'b1, '{12'd16, ST_OK, 1'b0}});
		// last 16 bytes would give data offset 4096: skipped
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd0,    1'b1, '{12'd0, ST_NOSPACE, 1'b0}});
		plan.push_back('{ACT_FREE,   12'd16,   12'd0,    1'b1, '{12'd0, ST_OK, 1'b0}});
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd100,  1'b0, none});
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd200,  1'b0, none});
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd50,   1'b0, none});
		// boxed in by neighbors: must move
		plan.push_back('{ACT_RESIZE, 12'd132,  12'd400,  1'b0, none});
		plan.push_back('{ACT_FREE,   12'd16,   12'd0,    1'b0, none});
		// fits before the head
		plan.push_back('{ACT_ALLOC,  12'd0,    12'd80,   1'b0, none});
		// neither in place nor elsewhere: old block kept
		plan.push_back('{ACT_RESIZE, 12'd348,  12'd4000, 1'b0, none});
		plan.push_back('{ACT_FREE,   12'd4095, 12'd0,    1'b1, '{12'd0, ST_BADADDR, 1'b0}});
		plan.push_back('{ACT_RESIZE, 12'd2730, 12'd2730, 1'b0, none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i].act, plan[i].off, plan[i].req, plan[i].typed, plan[i].want, got);

		// hold off until the block has answered everything
		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);

		for (int i = 0; i < MAX_BLOCKS; i++)
			if (blk_live[i])
				live_offs.push_back(blk_start[i] + HEADER_BYTES);

		fill = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n * 3 / RANDOM_ITEMS)
				0: gap_pct = 22;
				1: gap_pct = 63;
				default: gap_pct = 0;
			endcase
			pick = $urandom_range(99);
			if ($urandom_range(99) < 70)
				req = $urandom_range(0, 120);
			else if ($urandom_range(99) < 70)
				req = $urandom_range(0, 600);
			else
				req = $urandom_range(0, 4095);

			// one burst of header-only blocks runs the arena full
			if (n == RANDOM_ITEMS / 2 && fill == 0)
				fill = MAX_BLOCKS + 10;
			if (fill > 0) begin
				fill--;
				issue(ACT_ALLOC, 0, 0, 1'b0, none, got);
				if (got.st == ST_OK)
					live_offs.push_back(got.offset);
				if (fill == 0)
					// then release most of it again
					while (live_offs.size() > 8) begin
						idx = $urandom_range(live_offs.size() - 1);
						issue(ACT_FREE, live_offs[idx], $urandom_range(4095), 1'b0, none, got);
						live_offs.delete(idx);
						n++;
					end
				continue;
			end

			if (pick < 45 || live_offs.size() == 0) begin
				issue(ACT_ALLOC, $urandom_range(4095), req, 1'b0, none, got);
				if (got.st == ST_OK)
					live_offs.push_back(got.offset);
			end else if (pick < 73) begin
				idx = $urandom_range(live_offs.size() - 1);
				issue(ACT_FREE, live_offs[idx], $urandom_range(4095), 1'b0, none, got);
				if (got.st == ST_OK)
					live_offs.delete(idx);
			end else if (pick < 94) begin
				idx = $urandom_range(live_offs.size() - 1);
				issue(ACT_RESIZE, live_offs[idx], req, 1'b0, none, got);
				if (got.st == ST_OK)
					live_offs[idx] = got.offset;
			end else begin
				// noise: stray offsets and the unused action
				d = $urandom_range(4095);
				issue(($urandom_range(1) != 0) ? ACT_NONE : 2'(1 + $urandom_range(1)),
					d, $urandom_range(4095), 1'b0, none, got);
				for (int k = 0; k < live_offs.size(); k++)
					if (live_offs[k] == d && got.mv) begin
						live_offs[k] = got.offset;
						break;
					end else if (live_offs[k] == d && find_block(d) == MAX_BLOCKS) begin
						live_offs.delete(k);
						break;
					end
			end
		end
		start <= 1'b0;

		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
